[sv/mi4_pkg.sv]
package mi4_pkg;

   // default fraction bits of every element and result
   localparam int FRACTION_BITS_DEF = 16;
   // exact intermediate width for products, sums and the quotient search
   localparam int WIDE_BITS = 192;
   localparam int ELEM_BITS = 32;
   localparam int ELEM_COUNT = 16;
   localparam int INDEX_BITS = $clog2(ELEM_COUNT);
   // permutations of a 3x3 minor
   localparam int PERM_COUNT = 6;

   typedef struct packed {
      logic signed [ELEM_BITS-1:0] element_value;
      logic [INDEX_BITS-1:0]       element_index;
      logic                        start_req;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_BITS-1:0] result_value;
      logic [INDEX_BITS-1:0]       result_index;
      logic                        singular;
      logic                        saturated;
      logic                        last;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic                  store;
      logic                  ram_rd;
      logic [INDEX_BITS-1:0] ram_addr;
      logic                  p_load;
      logic                  mul_start;
      logic                  mul_from_c;
      logic                  c_clear;
      logic                  c_acc;
      logic                  c_neg;
      logic                  det_clear;
      logic                  det_acc;
      logic                  div_start;
      logic                  out_load;
      logic                  out_ident;
      logic [INDEX_BITS-1:0] out_index;
   } mi4_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic det_zero;
      logic out_free;
   } mi4_status_type;

   // column of the minor picked by factor fac under permutation perm
   function automatic logic [1:0] perm_pick(input logic [2:0] perm, input logic [1:0] fac);
      logic [5:0] tab;
      begin
         unique case (perm)
            3'd0: tab = {2'd2, 2'd1, 2'd0};
            3'd1: tab = {2'd1, 2'd2, 2'd0};
            3'd2: tab = {2'd2, 2'd0, 2'd1};
            3'd3: tab = {2'd0, 2'd2, 2'd1};
            3'd4: tab = {2'd1, 2'd0, 2'd2};
            3'd5: tab = {2'd0, 2'd1, 2'd2};
            default: tab = {2'd2, 2'd1, 2'd0};
         endcase
         case (fac)
            2'd0: perm_pick = tab[1:0];
            2'd1: perm_pick = tab[3:2];
            default: perm_pick = tab[5:4];
         endcase
      end
   endfunction

   // odd permutations subtract
   function automatic logic perm_neg(input logic [2:0] perm);
      perm_neg = (perm == 3'd1) || (perm == 3'd2) || (perm == 3'd5);
   endfunction

   // skip the excluded line when mapping a minor index to a full index
   function automatic logic [1:0] skip_line(input logic [1:0] m, input logic [1:0] excl);
      skip_line = (m < excl) ? m : 2'(m + 2'd1);
   endfunction

   // store address of minor element (fac, perm_pick) of cofactor (row, col)
   function automatic logic [INDEX_BITS-1:0] elem_addr(input logic [1:0] row,
                                                       input logic [1:0] col,
                                                       input logic [2:0] perm,
                                                       input logic [1:0] fac);
      elem_addr = {skip_line(perm_pick(perm, fac), col), skip_line(fac, row)};
   endfunction

endpackage

[sv/matrix_inverse_4x4_unit.sv]
// timing: a start request's run is set by the one-bit-per-cycle shift-add multiplier
//   and the 192-step restoring divider per element; a singular matrix skips the
//   divider and finishes sooner
// throughput: one matrix at a time; identity results stream one per cycle when taken
// reset: synchronous active high; all store entries read as zero until written
module matrix_inverse_4x4_unit import mi4_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   mi4_cmd_type    cmd;
   mi4_status_type status;

   // sequencer
   mi4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_start (req_data.start_req),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, arithmetic and result register
   mi4_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

[sv/mi4_ram.sv]
module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/mi4_datapath.sv]
module mi4_datapath import mi4_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   input  mi4_cmd_type    cmd,
   output mi4_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);
   localparam int W = WIDE_BITS;
   localparam int MUL_STEPS = ELEM_BITS;
   localparam int DIV_STEPS = W;
   localparam int SHIFT = 2 * FRACTION_BITS;
   localparam logic [ELEM_BITS-1:0] ONE_VAL = ELEM_BITS'(1) << FRACTION_BITS;
   localparam logic [ELEM_BITS-1:0] POS_LIMIT = {1'b0, {(ELEM_BITS-1){1'b1}}};
   localparam logic [ELEM_BITS-1:0] NEG_LIMIT = {1'b1, {(ELEM_BITS-1){1'b0}}};

   function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
      abs_w = v[W-1] ? W'(-v) : v;
   endfunction

   logic [ELEM_BITS-1:0] ram_q;
   logic [ELEM_COUNT-1:0] valid_ff, valid_in;
   logic vrd_ff, vrd_in;
   logic [ELEM_BITS-1:0] elem;
   logic [W-1:0] elem_w;

   logic [W-1:0] p_ff, p_in, c_ff, c_in, d_ff, d_in;
   logic [W-1:0] m_ff, m_in, r_ff, r_in, mul_sum;
   logic [ELEM_BITS-1:0] q_ff, q_in;
   logic [$clog2(MUL_STEPS)-1:0] mul_cnt_ff, mul_cnt_in;
   logic mul_busy_ff, mul_busy_in, mul_last;

   logic [W-1:0] num_ff, num_in, dabs_ff, dabs_in, rem_ff, rem_in;
   logic [W:0] rem_shift, rem_diff;
   logic rem_ge;
   logic [ELEM_BITS-1:0] qlow_ff, qlow_in;
   logic qhi_ff, qhi_in, neg_ff, neg_in;
   logic [$clog2(DIV_STEPS)-1:0] div_cnt_ff, div_cnt_in;
   logic div_busy_ff, div_busy_in, div_last;

   logic [ELEM_BITS-1:0] limit, mag;
   logic sat;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   mi4_ram #(.WIDTH(ELEM_BITS), .DEPTH(ELEM_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (req_data.element_index),
      .wr_data (req_data.element_value),
      .rd_en   (cmd.ram_rd),
      .rd_addr (cmd.ram_addr),
      .rd_data (ram_q)
   );

   // written flags: an unwritten entry reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (cmd.store) begin
         valid_in[req_data.element_index] = 1'b1;
      end
      vrd_in = cmd.ram_rd ? valid_ff[cmd.ram_addr] : vrd_ff;
   end
   assign elem = vrd_ff ? ram_q : '0;
   assign elem_w = {{(W-ELEM_BITS){elem[ELEM_BITS-1]}}, elem};

   // shift-add multiplier, element as signed multiplier, one bit a cycle
   assign mul_last = mul_busy_ff && (mul_cnt_ff == ($clog2(MUL_STEPS))'(MUL_STEPS - 1));
   assign mul_sum = r_ff + (q_ff[0] ? (mul_last ? W'(-m_ff) : m_ff) : '0);
   always_comb begin
      m_in = m_ff;
      q_in = q_ff;
      r_in = r_ff;
      mul_cnt_in = mul_cnt_ff;
      mul_busy_in = mul_busy_ff;
      if (cmd.mul_start) begin
         m_in = cmd.mul_from_c ? c_ff : p_ff;
         q_in = elem;
         r_in = '0;
         mul_cnt_in = '0;
         mul_busy_in = 1'b1;
      end else if (mul_busy_ff) begin
         m_in = m_ff << 1;
         q_in = q_ff >> 1;
         r_in = mul_sum;
         mul_cnt_in = mul_cnt_ff + 1'b1;
         mul_busy_in = !mul_last;
      end
   end

   // term, cofactor and determinant accumulators
   always_comb begin
      p_in = p_ff;
      if (cmd.p_load) begin
         p_in = elem_w;
      end else if (mul_last) begin
         p_in = mul_sum;
      end
      c_in = c_ff;
      if (cmd.c_clear) begin
         c_in = '0;
      end else if (cmd.c_acc) begin
         c_in = c_ff + (cmd.c_neg ? W'(-p_ff) : p_ff);
      end
      d_in = d_ff;
      if (cmd.det_clear) begin
         d_in = '0;
      end else if (cmd.det_acc) begin
         d_in = d_ff + p_ff;
      end
   end

   // restoring divider, one quotient bit a cycle, low 32 bits kept
   assign div_last = div_busy_ff && (div_cnt_ff == ($clog2(DIV_STEPS))'(DIV_STEPS - 1));
   assign rem_shift = {rem_ff, num_ff[W-1]};
   assign rem_ge = rem_shift >= {1'b0, dabs_ff};
   assign rem_diff = rem_shift - {1'b0, dabs_ff};
   always_comb begin
      num_in = num_ff;
      dabs_in = dabs_ff;
      rem_in = rem_ff;
      qlow_in = qlow_ff;
      qhi_in = qhi_ff;
      neg_in = neg_ff;
      div_cnt_in = div_cnt_ff;
      div_busy_in = div_busy_ff;
      if (cmd.div_start) begin
         num_in = abs_w(c_ff) << SHIFT;
         dabs_in = abs_w(d_ff);
         rem_in = '0;
         qlow_in = '0;
         qhi_in = 1'b0;
         neg_in = c_ff[W-1] ^ d_ff[W-1];
         div_cnt_in = '0;
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         num_in = num_ff << 1;
         rem_in = rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
         qlow_in = {qlow_ff[ELEM_BITS-2:0], rem_ge};
         qhi_in = qhi_ff | qlow_ff[ELEM_BITS-1];
         div_cnt_in = div_cnt_ff + 1'b1;
         div_busy_in = !div_last;
      end
   end

   // sign, saturation and output register
   assign limit = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign sat = qhi_ff || (qlow_ff > limit);
   assign mag = sat ? limit : qlow_ff;
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.result_index = cmd.out_index;
         rsp_in.last = (cmd.out_index == INDEX_BITS'(ELEM_COUNT - 1));
         if (cmd.out_ident) begin
            rsp_in.result_value = (cmd.out_index[1:0] == cmd.out_index[3:2]) ? ONE_VAL : '0;
            rsp_in.singular = 1'b1;
            rsp_in.saturated = 1'b0;
         end else begin
            rsp_in.result_value = neg_ff ? ELEM_BITS'(-mag) : mag;
            rsp_in.singular = 1'b0;
            rsp_in.saturated = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mul_busy_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         mul_busy_ff <= mul_busy_in;
         div_busy_ff <= div_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vrd_ff <= vrd_in;
      p_ff <= p_in;
      c_ff <= c_in;
      d_ff <= d_in;
      m_ff <= m_in;
      q_ff <= q_in;
      r_ff <= r_in;
      mul_cnt_ff <= mul_cnt_in;
      num_ff <= num_in;
      dabs_ff <= dabs_in;
      rem_ff <= rem_in;
      qlow_ff <= qlow_in;
      qhi_ff <= qhi_in;
      neg_ff <= neg_in;
      div_cnt_ff <= div_cnt_in;
      rsp_ff <= rsp_in;
   end

   assign status.mul_done = mul_last;
   assign status.div_done = div_last;
   assign status.det_zero = (d_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // multiplier and divider never run together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_busy_ff && div_busy_ff))
      else $error("multiplier and divider busy together");

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result register overwritten");

   // a started multiply is busy on the next cycle
   a_mul_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> mul_busy_ff)
      else $error("multiply did not start");
endmodule

[sv/mi4_ctrl.sv]
module mi4_ctrl import mi4_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_start,
   output logic           req_ready,
   input  mi4_status_type status,
   output mi4_cmd_type    cmd
);
   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_COF_INIT = 14'b00000000000010,
      ST_COF_RD   = 14'b00000000000100,
      ST_COF_LD   = 14'b00000000001000,
      ST_COF_MUL  = 14'b00000000010000,
      ST_COF_ACC  = 14'b00000000100000,
      ST_DET_RD   = 14'b00000001000000,
      ST_DET_LD   = 14'b00000010000000,
      ST_DET_MUL  = 14'b00000100000000,
      ST_DET_ACC  = 14'b00001000000000,
      ST_CHECK    = 14'b00010000000000,
      ST_IDENT    = 14'b00100000000000,
      ST_DIV      = 14'b01000000000000,
      ST_EMIT     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] perm_ff, perm_in;
   logic [1:0] fac_ff, fac_in, j_ff, j_in;
   logic [INDEX_BITS-1:0] k_ff, k_in;
   logic det_phase_ff, det_phase_in;
   logic [1:0] row, col;
   logic accept;

   // cofactor position: first row during the determinant, else item k
   assign row = det_phase_ff ? 2'd0 : k_ff[3:2];
   assign col = det_phase_ff ? j_ff : k_ff[1:0];
   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      perm_in = perm_ff;
      fac_in = fac_ff;
      j_in = j_ff;
      k_in = k_ff;
      det_phase_in = det_phase_ff;
      cmd = '0;
      cmd.store = accept;
      cmd.ram_addr = elem_addr(row, col, perm_ff, fac_ff);
      cmd.out_index = k_ff;
      cmd.c_neg = perm_neg(perm_ff) ^ row[0] ^ col[0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_start) begin
               det_phase_in = 1'b1;
               j_in = '0;
               cmd.det_clear = 1'b1;
               state_in = ST_COF_INIT;
            end
         end
         ST_COF_INIT: begin
            cmd.c_clear = 1'b1;
            perm_in = '0;
            fac_in = '0;
            state_in = ST_COF_RD;
         end
         ST_COF_RD: begin
            cmd.ram_rd = 1'b1;
            state_in = ST_COF_LD;
         end
         ST_COF_LD: begin
            if (fac_ff == 2'd0) begin
               cmd.p_load = 1'b1;
               fac_in = 2'd1;
               state_in = ST_COF_RD;
            end else begin
               cmd.mul_start = 1'b1;
               state_in = ST_COF_MUL;
            end
         end
         ST_COF_MUL: begin
            if (status.mul_done) begin
               if (fac_ff == 2'd2) begin
                  state_in = ST_COF_ACC;
               end else begin
                  fac_in = fac_ff + 2'd1;
                  state_in = ST_COF_RD;
               end
            end
         end
         ST_COF_ACC: begin
            cmd.c_acc = 1'b1;
            fac_in = '0;
            if (perm_ff == 3'(PERM_COUNT - 1)) begin
               state_in = det_phase_ff ? ST_DET_RD : ST_DIV;
               cmd.ram_addr = {j_ff, 2'd0};
            end else begin
               perm_in = perm_ff + 3'd1;
               state_in = ST_COF_RD;
            end
         end
         ST_DET_RD: begin
            cmd.ram_rd = 1'b1;
            cmd.ram_addr = {j_ff, 2'd0};
            state_in = ST_DET_LD;
         end
         ST_DET_LD: begin
            cmd.mul_start = 1'b1;
            cmd.mul_from_c = 1'b1;
            state_in = ST_DET_MUL;
         end
         ST_DET_MUL: begin
            if (status.mul_done) begin
               state_in = ST_DET_ACC;
            end
         end
         ST_DET_ACC: begin
            cmd.det_acc = 1'b1;
            if (j_ff == 2'd3) begin
               state_in = ST_CHECK;
            end else begin
               j_in = j_ff + 2'd1;
               state_in = ST_COF_INIT;
            end
         end
         ST_CHECK: begin
            det_phase_in = 1'b0;
            k_in = '0;
            state_in = status.det_zero ? ST_IDENT : ST_COF_INIT;
         end
         ST_IDENT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_ident = 1'b1;
               k_in = k_ff + 1'b1;
               if (k_ff == INDEX_BITS'(ELEM_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            // start in the cycle after the last cofactor term is added, then wait
            if (!status.div_done && (perm_ff != 3'd0)) begin
               cmd.div_start = 1'b1;
               perm_in = '0;
            end else if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               k_in = k_ff + 1'b1;
               state_in = (k_ff == INDEX_BITS'(ELEM_COUNT - 1)) ? ST_IDLE : ST_COF_INIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         perm_ff <= '0;
         fac_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         det_phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         perm_ff <= perm_in;
         fac_ff <= fac_in;
         j_ff <= j_in;
         k_ff <= k_in;
         det_phase_ff <= det_phase_in;
      end
   end

   // a request is taken only while nothing is in flight
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> !status.div_done && !status.mul_done)
      else $error("request taken while busy");

   // a start request always leads into the determinant
   a_start_det: assert property (@(posedge clock) disable iff (reset)
      (accept && req_start) |=> (state_ff == ST_COF_INIT) && det_phase_ff)
      else $error("start did not begin determinant");

   // results are loaded only after the determinant phase ends
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !det_phase_ff)
      else $error("result loaded during determinant");
endmodule

[verif/mi4_inverse_checker.sv]
module mi4_inverse_checker import mi4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = FRACTION_BITS_DEF;

   typedef logic signed [WIDE_BITS-1:0] wide_type;

   logic signed [ELEM_BITS-1:0] element_store [ELEM_COUNT];
   rsp_type inverse_expected [$];

   // stored element at (row, col), sign extended to the exact width
   function automatic wide_type elem_at(input int row, input int col);
      wide_type w;
      w = element_store[(col * 4 + row) & 15];
      return w;
   endfunction

   // signed cofactor of (row, col)
   function automatic wide_type cofactor_of(input int row, input int col);
      int rs [3];
      int cs [3];
      int n;
      wide_type a [3][3];
      wide_type m;
      n = 0;
      for (int i = 0; i < 4; i++) if (i != row) begin rs[n] = i; n++; end
      n = 0;
      for (int i = 0; i < 4; i++) if (i != col) begin cs[n] = i; n++; end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) a[i][j] = elem_at(rs[i], cs[j]);
      m = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1]);
      m = m - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0]);
      m = m + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
      return ((row + col) & 1) ? -m : m;
   endfunction

   // queue the 16 inverse elements of the current store
   task automatic predict_inverse();
      wide_type det;
      wide_type cof;
      logic [WIDE_BITS-1:0] det_mag;
      logic [WIDE_BITS-1:0] num;
      logic [WIDE_BITS-1:0] quo;
      logic det_neg;
      logic neg;
      logic sat;
      logic [31:0] limit;
      logic [31:0] mag;
      rsp_type r;
      det = '0;
      for (int j = 0; j < 4; j++) det = det + elem_at(0, j) * cofactor_of(0, j);
      det_neg = det < 0;
      det_mag = det_neg ? -det : det;
      for (int k = 0; k < ELEM_COUNT; k++) begin
         r.result_index = INDEX_BITS'(k);
         r.last = (k == ELEM_COUNT - 1);
         if (det == 0) begin
            r.result_value = ((k & 3) == (k >> 2)) ? 32'(1 << FRAC) : '0;
            r.singular = 1'b1;
            r.saturated = 1'b0;
         end else begin
            cof = cofactor_of(k >> 2, k & 3);
            neg = cof < 0;
            num = neg ? -cof : cof;
            num = num << (2 * FRAC);
            quo = num / det_mag;
            neg = neg ^ det_neg;
            limit = neg ? 32'h8000_0000 : 32'h7fff_ffff;
            sat = (|quo[WIDE_BITS-1:32]) || (quo[31:0] > limit);
            mag = sat ? limit : quo[31:0];
            r.result_value = neg ? -mag : mag;
            r.singular = 1'b0;
            r.saturated = sat;
         end
         inverse_expected.push_back(r);
      end
   endtask

   // track stored elements and compare every response
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < ELEM_COUNT; i++) element_store[i] = '0;
         inverse_expected.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (inverse_expected.size() == 0) begin
               $error("unexpected response index %0d", rsp_data.result_index);
               fail_count <= fail_count + 1;
            end else begin
               e = inverse_expected.pop_front();
               if (rsp_data.result_value !== e.result_value ||
                   rsp_data.result_index !== e.result_index ||
                   rsp_data.singular !== e.singular ||
                   rsp_data.saturated !== e.saturated ||
                   rsp_data.last !== e.last) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.result_value !== e.result_value)
                     $error("result_value exp %h got %h", e.result_value,
                            rsp_data.result_value);
                  if (rsp_data.result_index !== e.result_index)
                     $error("result_index exp %0d got %0d", e.result_index,
                            rsp_data.result_index);
                  if (rsp_data.singular !== e.singular)
                     $error("singular exp %b got %b", e.singular, rsp_data.singular);
                  if (rsp_data.saturated !== e.saturated)
                     $error("saturated exp %b got %b", e.saturated, rsp_data.saturated);
                  if (rsp_data.last !== e.last)
                     $error("last exp %b got %b", e.last, rsp_data.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            element_store[req_data.element_index] = req_data.element_value;
            if (req_data.start_req) predict_inverse();
         end
         pending_count <= inverse_expected.size();
      end
   end

endmodule

[verif/testbench.sv]
module testbench import mi4_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TARGET_ITEMS = 310;
   localparam int IDLE_LIMIT = 60000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      item_count = 0;
   int      burst_left = 0;
   int      idle_cycles = 0;

   matrix_inverse_4x4_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   mi4_inverse_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #6 clock = ~clock;

   // receiver stall pattern, re-chosen when the low six phase bits are zero
   always @(negedge clock) begin
      int phase;
      int stall_mode;
      phase = phase + 1;
      if ((phase & 63) == 0) stall_mode = $urandom_range(0, 3);
      if (reset) rsp_ready <= 1'b0;
      else case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((phase & 15) < 12);
      endcase
   end

   // no acceptance for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // one request, sent in bursts with random gaps
   task automatic send_elem(input logic [31:0] v, input logic [3:0] idx, input logic st);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_data.element_value <= v;
      req_data.element_index <= idx;
      req_data.start_req <= st;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      item_count++;
   endtask

   // element value by matrix flavor
   function automatic logic [31:0] rand_elem(input int flavor);
      case (flavor)
         0: return {16'($urandom_range(0, 15) - 8), 16'($urandom)};
         1: return $urandom;
         2: return $urandom_range(0, 255) - 128;
         default: return {16'($urandom_range(0, 3) - 2), 16'($urandom)};
      endcase
   endfunction

   // load a matrix in random order, the final element carrying start
   task automatic send_matrix(input int flavor, input bit make_singular);
      logic [31:0] m [16];
      int order [16];
      int t;
      int j;
      int skip;
      int r1;
      int r2;
      for (int k = 0; k < 16; k++) begin
         m[k] = rand_elem(flavor);
         order[k] = k;
      end
      if (flavor == 3)
         for (int k = 0; k < 4; k++) m[k * 5] = m[k * 5] + 32'h0004_0000;
      if (make_singular) begin
         r1 = $urandom_range(0, 3);
         r2 = (r1 + $urandom_range(1, 3)) & 3;
         for (int c = 0; c < 4; c++) m[c * 4 + r2] = m[c * 4 + r1];
      end
      for (int k = 15; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      skip = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      for (int k = skip; k < 16; k++) send_elem(m[order[k]], 4'(order[k]), k == 15);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty store, identity, extremes
      send_elem(32'h0, 4'd3, 1'b1);
      send_elem(32'h0, 4'd3, 1'b0);
      for (int k = 0; k < 4; k++) send_elem(32'h0001_0000, 4'(k * 5), k == 3);
      send_elem(32'h0002_0000, 4'd5, 1'b0);
      send_elem(32'hffff_8000, 4'd10, 1'b1);
      send_elem(32'h7fff_ffff, 4'd0, 1'b0);
      send_elem(32'h8000_0000, 4'd15, 1'b1);
      send_elem(32'h0000_0001, 4'd0, 1'b0);
      send_elem(32'h0000_0001, 4'd5, 1'b0);
      send_elem(32'h0000_0001, 4'd10, 1'b0);
      send_elem(32'h0000_0001, 4'd15, 1'b1);
      send_elem(32'h8000_0000, 4'd1, 1'b0);
      send_elem(32'h7fff_ffff, 4'd4, 1'b1);

      // random matrices, mostly well formed, with noise between
      while (item_count < TARGET_ITEMS) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 6))
               send_elem($urandom, 4'($urandom), $urandom_range(0, 15) == 0);
         else
            send_matrix($urandom_range(0, 3), $urandom_range(0, 4) == 0);
      end
      req_valid <= 1'b0;

      // drain
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
